/* rtl/sorted_member_table_lookup_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted member table lookup unit
// Implication checks on the rising clock, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_MEMBER_TABLE_LOOKUP_UNIT_MACROS_SVH
`define SORTED_MEMBER_TABLE_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication: pre holds -> post holds in that cycle.
`define SMTL_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("smtl assertion failed");

// Next-cycle implication: pre holds -> post holds in the next cycle.
`define SMTL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("smtl assertion failed");

`endif

/* rtl/smtl_pkg.sv */
// ----------------------------------------------------------------------------
// smtl_pkg
// Shared constants, codes and types of the sorted member table lookup unit.
// ----------------------------------------------------------------------------
package smtl_pkg;

    localparam int TABLE_DEPTH   = 128;
    localparam int MATE_BIT      = 20;
    localparam int NUM_W         = 20;
    localparam int KEY_W         = (MATE_BIT >= NUM_W) ? (MATE_BIT + 2) : (NUM_W + 1);
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_CNT_W     = 8;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_FRIEND  = 2'd0,
        KIND_SPECIAL = 2'd1,
        KIND_BAD     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_CHECK,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
        logic                    key_ok;
        logic                    is_bad;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic lt;   // table word below the key
        logic eq;   // table word equal to the key
    } t_cmp;

endpackage

/* rtl/sorted_member_table_lookup_unit.sv */
// ----------------------------------------------------------------------------
// sorted_member_table_lookup_unit
// Sorted signed-key membership table with clear, add and query words.
// ----------------------------------------------------------------------------
// Each input word is handled alone and gives exactly one result word. A clear
// or an ignored word is taken in the idle state and goes to the done state,
// from which its result enters the output register. A query runs a binary
// search on the one table read port with one shared signed comparator: each
// halving step reads in the search state and moves a bound in the compare
// state, then the check state tests for equality. An add searches the same
// way for its slot, then moves every larger entry up one place through the
// same read port (read in the shift state, written in the shift-write state).
// A finished word waits in the done state while the output register is full.
// Input ready is high only while the sequencer is idle; a result waits in the
// output register while the next word is already being taken and worked on.
// The configuration register (bad-kind query enable) is always writable.
// ----------------------------------------------------------------------------
module sorted_member_table_lookup_unit
    import smtl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_operation,
    input  logic [NUM_W-1:0]     i_user_number,
    input  logic [1:0]           i_entry_kind,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_found,
    output logic [OUT_CNT_W-1:0] o_entry_count,
    output logic                 o_overflow,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data
);

    logic                 r_bad_query_enable;
    logic                 r_out_valid;
    logic                 r_found;
    logic [OUT_CNT_W-1:0] r_entry_count;
    logic                 r_overflow;

    t_item            item;
    logic [KEY_W-1:0] num_ext;
    logic             idle;
    logic             done;
    logic             slot_free;
    t_result          result;
    t_ram_req         ram_req;
    logic [KEY_W-1:0] ram_rdata;
    logic [KEY_W-1:0] search_key;
    t_cmp             cmp;

    // Key forming: friend = +n, special = n with mate bit, bad = -n.
    assign num_ext = KEY_W'(i_user_number);

    always_comb begin
        item.op     = t_op'(i_operation);
        item.key    = num_ext;
        item.key_ok = 1'b1;
        item.is_bad = 1'b0;
        case (t_kind'(i_entry_kind))
            KIND_FRIEND: begin
                item.key = num_ext;
            end
            KIND_SPECIAL: begin
                item.key = num_ext | (KEY_W'(1) << MATE_BIT);
            end
            KIND_BAD: begin
                item.key    = KEY_W'(0) - num_ext;
                item.is_bad = 1'b1;
            end
            default: begin
                item.key_ok = 1'b0;
            end
        endcase
    end

    assign o_in_ready  = idle;
    assign o_cfg_ready = 1'b1;

    // Output register frees up when empty or taken this cycle.
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_query_enable <= 1'b1;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bad_query_enable <= i_cfg_data;
            end
            if (done && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && slot_free) begin
            r_found       <= result.found;
            r_entry_count <= OUT_CNT_W'(result.count);
            r_overflow    <= result.overflow;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_entry_count = r_entry_count;
    assign o_overflow    = r_overflow;

    smtl_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item_valid       (i_in_valid),
        .i_item             (item),
        .i_bad_query_enable (r_bad_query_enable),
        .o_idle             (idle),
        .o_ram_req          (ram_req),
        .i_ram_rdata        (ram_rdata),
        .i_cmp              (cmp),
        .i_slot_free        (slot_free),
        .o_done             (done),
        .o_key              (search_key),
        .o_result           (result)
    );

    smtl_key_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Single comparator shared by search steps and the final equality check.
    smtl_key_cmp u_cmp (
        .i_data (ram_rdata),
        .i_key  (search_key),
        .o_res  (cmp)
    );

endmodule

/* rtl/smtl_key_ram.sv */
// ----------------------------------------------------------------------------
// smtl_key_ram
// Key table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module smtl_key_ram
    import smtl_pkg::*;
(
    input  logic             i_clk,
    input  t_ram_req         i_req,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/smtl_key_cmp.sv */
// ----------------------------------------------------------------------------
// smtl_key_cmp
// Shared signed comparator: table word against the search key.
// ----------------------------------------------------------------------------
module smtl_key_cmp
    import smtl_pkg::*;
(
    input  logic [KEY_W-1:0] i_data,
    input  logic [KEY_W-1:0] i_key,
    output t_cmp             o_res
);

    always_comb begin
        o_res.lt = ($signed(i_data) < $signed(i_key));
        o_res.eq = (i_data == i_key);
    end

endmodule

/* rtl/smtl_ctrl.sv */
// ----------------------------------------------------------------------------
// smtl_ctrl
// Sequencer: binary search over the table, shift-insert, count and overflow.
// ----------------------------------------------------------------------------
`include "sorted_member_table_lookup_unit_macros.svh"

module smtl_ctrl
    import smtl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  t_item            i_item,
    input  logic             i_bad_query_enable,
    output logic             o_idle,
    output t_ram_req         o_ram_req,
    input  logic [KEY_W-1:0] i_ram_rdata,
    input  t_cmp             i_cmp,
    input  logic             i_slot_free,
    output logic             o_done,
    output logic [KEY_W-1:0] o_key,
    output t_result          o_result
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_is_add, n_is_add;
    logic             r_found, n_found;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_pos, n_pos;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] pos_m1;
    logic             go_right;
    logic             ins_last;
    logic             done_stall;
    logic [CNT_W-1:0] count_inc;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CNT_W:1];
    assign pos_m1   = r_pos - CNT_W'(1);
    assign go_right = i_cmp.lt || (r_is_add && i_cmp.eq);

    // Helpers for the checks below.
    assign ins_last   = (r_state == ST_SHIFT) && (r_pos == r_lo);
    assign done_stall = (r_state == ST_DONE) && !i_slot_free;
    assign count_inc  = r_count + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_is_add <= n_is_add;
        r_found  <= n_found;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_pos    <= n_pos;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_key     = r_key;
        n_is_add  = r_is_add;
        n_found   = r_found;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_pos     = r_pos;
        o_ram_req = '0;
        o_ram_req.raddr = r_lo[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_found  = 1'b0;
                    n_key    = i_item.key;
                    n_is_add = (i_item.op == OP_ADD);
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_state  = ST_DONE;
                    case (i_item.op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        OP_ADD: begin
                            if (i_item.key_ok && !r_ovf) begin
                                if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_state = ST_SEARCH;
                                end
                            end
                        end
                        OP_QUERY: begin
                            if (i_item.key_ok && !r_ovf &&
                                !(i_item.is_bad && !i_bad_query_enable)) begin
                                n_state = ST_SEARCH;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (r_lo == r_hi) begin
                    if (r_is_add) begin
                        n_pos   = r_count;
                        n_state = ST_SHIFT;
                    end else begin
                        o_ram_req.raddr = r_lo[IDX_W-1:0];
                        n_state         = ST_CHECK;
                    end
                end else begin
                    o_ram_req.raddr = mid[IDX_W-1:0];
                    n_mid           = mid;
                    n_state         = ST_CMP;
                end
            end
            ST_CMP: begin
                if (go_right) begin
                    n_lo = r_mid + CNT_W'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = ST_SEARCH;
            end
            ST_CHECK: begin
                n_found = i_cmp.eq && (r_lo < r_count);
                n_state = ST_DONE;
            end
            ST_SHIFT: begin
                if (r_pos == r_lo) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_lo[IDX_W-1:0];
                    o_ram_req.wdata = r_key;
                    n_count         = r_count + CNT_W'(1);
                    n_state         = ST_DONE;
                end else begin
                    o_ram_req.raddr = pos_m1[IDX_W-1:0];
                    n_state         = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_pos[IDX_W-1:0];
                o_ram_req.wdata = i_ram_rdata;
                n_pos           = pos_m1;
                n_state         = ST_SHIFT;
            end
            ST_DONE: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle            = (r_state == ST_IDLE);
    assign o_done            = (r_state == ST_DONE);
    assign o_key             = r_key;
    assign o_result.found    = r_found;
    assign o_result.count    = r_ovf ? '0 : r_count;
    assign o_result.overflow = r_ovf;

    `SMTL_ASSERT_SAME(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(TABLE_DEPTH))
    `SMTL_ASSERT_SAME(a_search_bounds, i_clk, i_rst_n, r_state == ST_SEARCH, r_lo <= r_hi)
    `SMTL_ASSERT_NEXT(a_insert_counts, i_clk, i_rst_n, ins_last, r_count == $past(count_inc))
    `SMTL_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, done_stall, r_state == ST_DONE)

endmodule

/* tb/tb_sorted_member_table_lookup_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_member_table_lookup_unit
// Self-checking bench for the sorted member table lookup unit. A scoreboard
// keeps its own sorted key table and predicts found, entry count and overflow
// for every accepted input word. A short directed run is followed by random
// clear/add/query sequences under three idling mixes on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_member_table_lookup_unit;
    import smtl_pkg::*;

    // Codes with no name in the package; the block must still handle them.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 330;  // random words per idling mix
    localparam int CFG_EVERY       = 110;  // rewrite the enable this often
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 300;  // longer than the longest add

    typedef logic signed [KEY_W-1:0] t_key;

    // One expected result word.
    typedef struct {
        logic                 found;
        logic [OUT_CNT_W-1:0] count;
        logic                 overflow;
    } t_status;

    // ------------------------------------------------------------------------
    // Scoreboard: models the table and holds expected result words in order.
    // ------------------------------------------------------------------------
    class member_scoreboard;
        t_key    keys[$];       // kept in ascending signed order
        bit      overflowed;
        bit      bad_enable;
        t_status expected[$];
        int      errors;

        function new();
            overflowed = 1'b0;
            bad_enable = 1'b1;
            errors     = 0;
        endfunction

        function void set_bad_enable(bit value);
            bad_enable = value;
        endfunction

        // Builds the signed key; returns 0 for the unused kind.
        function bit form_key(logic [1:0] kind, logic [NUM_W-1:0] num,
                              output t_key key);
            key = t_key'({{(KEY_W-NUM_W){1'b0}}, num});
            case (kind)
                KIND_FRIEND:  return 1'b1;
                KIND_SPECIAL: begin
                    key[MATE_BIT] = 1'b1;
                    return 1'b1;
                end
                KIND_BAD: begin
                    key = -key;
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function bit holds(t_key key);
            foreach (keys[i])
                if (keys[i] == key)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_word(logic [1:0] op, logic [NUM_W-1:0] num,
                                logic [1:0] kind);
            t_key    key;
            bit      ok;
            int      pos;
            t_status s;
            ok      = form_key(kind, num, key);
            s.found = 1'b0;
            case (op)
                OP_CLEAR: begin
                    keys.delete();
                    overflowed = 1'b0;
                end
                OP_ADD: begin
                    if (ok && !overflowed) begin
                        if (keys.size() >= TABLE_DEPTH) begin
                            overflowed = 1'b1;
                        end else begin
                            pos = 0;
                            while (pos < keys.size() && keys[pos] <= key)
                                pos++;
                            keys.insert(pos, key);
                        end
                    end
                end
                OP_QUERY: begin
                    if (ok && !overflowed && !(kind == KIND_BAD && !bad_enable))
                        s.found = holds(key);
                end
                default: ;
            endcase
            s.count    = overflowed ? '0 : OUT_CNT_W'(keys.size());
            s.overflow = overflowed;
            expected.push_back(s);
        endfunction

        function void check_word(logic found, logic [OUT_CNT_W-1:0] count, logic overflow);
            t_status s;
            if (expected.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
                return;
            end
            s = expected.pop_front();
            if (found !== s.found) begin
                $error("found: expected %0d, got %0d", s.found, found);
                errors++;
            end
            if (count !== s.count) begin
                $error("entry_count: expected %0d, got %0d", s.count, count);
                errors++;
            end
            if (overflow !== s.overflow) begin
                $error("overflow: expected %0d, got %0d", s.overflow, overflow);
                errors++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_operation   = '0;
    logic [NUM_W-1:0]     i_user_number = '0;
    logic [1:0]           i_entry_kind  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic                 o_found;
    logic [OUT_CNT_W-1:0] o_entry_count;
    logic                 o_overflow;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_data    = 1'b0;

    // Idle odds in percent per cycle, set by the main sequence per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    member_scoreboard sb;

    always #6 i_clk = ~i_clk;

    sorted_member_table_lookup_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_user_number (i_user_number),
        .i_entry_kind  (i_entry_kind),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_entry_count (o_entry_count),
        .o_overflow    (o_overflow),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: check on each handshake, then pick next cycle's ready.
    // Values read here are the ones from before the edge, since the block
    // and the bench both update with nonblocking assignments.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                sb.check_word(o_found, o_entry_count, o_overflow);
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Valid is only dropped when a gap is taken, so back to back
    // words never see a low and a high assignment in the same step.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [1:0] op, input logic [NUM_W-1:0] num,
                             input logic [1:0] kind);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_user_number <= num;
        i_entry_kind  <= kind;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(op, num, kind);
    endtask

    // Waits until every expected word has come back.
    task automatic drain_results();
        int cycles;
        cycles     = 0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (sb.pending() != 0)
            $error("results stalled: %0d still expected", sb.pending());
    endtask

    // Enable write, only with the block drained.
    task automatic write_bad_enable(input bit value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_bad_enable(value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [NUM_W-1:0] rand_number();
        return NUM_W'($urandom_range(0, (1 << NUM_W) - 1));
    endfunction

    // Words the block must tolerate: unused operation or unused kind.
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0:       send_word(OP_UNUSED, rand_number(), 2'($urandom_range(0, 3)));
            1:       send_word(OP_ADD, rand_number(), KIND_UNUSED);
            default: send_word(OP_QUERY, rand_number(), KIND_UNUSED);
        endcase
    endtask

    // One clear followed by adds and queries over a small pool of numbers, so
    // queries hit often and duplicates pile up. A fill sequence runs the table
    // to full or one short of it, and usually past it into overflow.
    task automatic run_sequence(input bit fill, inout int words);
        logic [NUM_W-1:0] pool[6];
        int               adds_target;
        int               adds_done;
        int               tail;
        int               r;
        logic [NUM_W-1:0] num;
        foreach (pool[i]) begin
            r = $urandom_range(0, 9);
            pool[i] = (r == 0) ? '0 : (r == 1) ? '1 : rand_number();
        end
        adds_target = fill ? $urandom_range(TABLE_DEPTH - 1, TABLE_DEPTH + 3)
                           : $urandom_range(1, 24);
        tail        = $urandom_range(2, 6);
        send_word(OP_CLEAR, rand_number(), 2'($urandom_range(0, 3)));
        words++;
        adds_done = 0;
        while (adds_done < adds_target || tail > 0) begin
            r = $urandom_range(0, 99);
            if (adds_done < adds_target && r < 55) begin
                send_word(OP_ADD, pool[$urandom_range(0, 5)], 2'($urandom_range(0, 2)));
                adds_done++;
                words++;
            end else if (r < 94) begin
                num = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 5)]
                                                  : rand_number();
                send_word(OP_QUERY, num, 2'($urandom_range(0, 2)));
                words++;
                if (adds_done >= adds_target)
                    tail--;
            end else begin
                send_noise();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int seq_idx;
        int words;
        int last_cfg;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 24;
        recv_idle_pct = 79;
        write_bad_enable(1'b1);

        // Directed: empty table, key extremes of every kind, zero shared by
        // friend and bad, duplicates, unused kind and operation.
        send_word(OP_CLEAR,  20'h00000, KIND_FRIEND);
        send_word(OP_QUERY,  20'h00000, KIND_FRIEND);
        send_word(OP_ADD,    20'h00000, KIND_FRIEND);
        send_word(OP_ADD,    20'h00000, KIND_BAD);
        send_word(OP_ADD,    20'hFFFFF, KIND_SPECIAL);
        send_word(OP_ADD,    20'hFFFFF, KIND_BAD);
        send_word(OP_ADD,    20'hFFFFF, KIND_FRIEND);
        send_word(OP_ADD,    20'h00000, KIND_SPECIAL);
        send_word(OP_ADD,    20'h55555, KIND_FRIEND);
        send_word(OP_ADD,    20'hAAAAA, KIND_BAD);
        send_word(OP_QUERY,  20'h00000, KIND_FRIEND);
        send_word(OP_QUERY,  20'h00000, KIND_BAD);
        send_word(OP_QUERY,  20'hFFFFF, KIND_SPECIAL);
        send_word(OP_QUERY,  20'hFFFFF, KIND_BAD);
        send_word(OP_QUERY,  20'h55555, KIND_SPECIAL);
        send_word(OP_QUERY,  20'h55555, KIND_BAD);
        send_word(OP_QUERY,  20'hAAAAA, KIND_FRIEND);
        send_word(OP_ADD,    20'h12345, KIND_UNUSED);
        send_word(OP_QUERY,  20'h00000, KIND_UNUSED);
        send_word(OP_UNUSED, 20'h00000, KIND_FRIEND);

        // Bad-kind queries disabled: bad adds still land in the table.
        write_bad_enable(1'b0);
        send_word(OP_QUERY,  20'hFFFFF, KIND_BAD);
        send_word(OP_QUERY,  20'hFFFFF, KIND_FRIEND);
        send_word(OP_ADD,    20'h00001, KIND_BAD);
        send_word(OP_QUERY,  20'h00001, KIND_BAD);
        send_word(OP_CLEAR,  20'hFFFFF, KIND_BAD);

        // Random: receiver-heavy idling, then sender-heavy, then none.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_bad_enable(phase == 1 ? 1'b0
                                        : (phase == 0 ? 1'b1 : 1'($urandom_range(0, 1))));
            seq_idx  = 0;
            words    = 0;
            last_cfg = 0;
            while (words < ITEMS_PER_PHASE) begin
                run_sequence(seq_idx == 1 || $urandom_range(0, 15) == 0, words);
                seq_idx++;
                if (words - last_cfg >= CFG_EVERY && words < ITEMS_PER_PHASE) begin
                    write_bad_enable(1'($urandom_range(0, 1)));
                    last_cfg = words;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $error("%0d expected result words never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #(64'd50_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
